// ----- hw/rtl/point_view_projection_clip_defines.svh -----
// ----------------------------------------------------------------------------
// Point projection assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POINT_VIEW_PROJECTION_CLIP_DEFINES_SVH
`define POINT_VIEW_PROJECTION_CLIP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PVP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PVP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PVP_ASSERT(lbl, ante, cons, msg)
`define PVP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/pvp_pkg.sv -----
// ----------------------------------------------------------------------------
// Point projection package
// Fixed widths, opcodes and register indexes of the projection block.
// ----------------------------------------------------------------------------
`default_nettype none
package pvp_pkg;
  localparam int WORD_W   = 32;
  localparam int ADDR_W   = 5;
  localparam int CFG_W    = 15;
  localparam int CFG_IDX_W = 2;
  localparam int SCREEN_W = 23;
  localparam logic [SCREEN_W-1:0] SCREEN_MAX = '1;

  // opcodes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_DEPTH = 2'd2;
endpackage
`default_nettype wire

// ----- hw/rtl/point_view_projection_clip.sv -----
// ----------------------------------------------------------------------------
// Point view/projection transform with clip test
// Stores view and projection matrices, projects points, maps to screen.
// ----------------------------------------------------------------------------
// A load beat (opcode 0) writes one matrix word and leaves busy low. A
// project beat runs 32 multiply-accumulates through one shared 32x32
// multiplier fed by the registered matrix store read, a clip test, then two
// restoring divisions on one shared divider, one per screen axis. A failed
// clip test skips the divisions and gives a hidden result; a zero viewport
// gives a hidden result straight from idle, with busy left low.
// The result appears on visible/screen_x/screen_y for one cycle with done
// high; the receiver cannot stall it, so it must take it then.
`default_nettype none
`include "point_view_projection_clip_defines.svh"
module point_view_projection_clip #(
  parameter int FRAC_BITS        = 16,
  parameter int SCREEN_FRAC_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic                          opcode,
  input  wire logic [pvp_pkg::ADDR_W-1:0]    entry_index,
  input  wire logic signed [pvp_pkg::WORD_W-1:0] entry_value,
  input  wire logic signed [pvp_pkg::WORD_W-1:0] point_x,
  input  wire logic signed [pvp_pkg::WORD_W-1:0] point_y,
  input  wire logic signed [pvp_pkg::WORD_W-1:0] point_z,
  output      logic                          done,
  output      logic                          visible,
  output      logic [pvp_pkg::SCREEN_W-1:0]  screen_x,
  output      logic [pvp_pkg::SCREEN_W-1:0]  screen_y,
  input  wire logic                          cfg_write,
  input  wire logic [pvp_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [pvp_pkg::CFG_W-1:0]     cfg_data
);
  import pvp_pkg::*;

  localparam int QW  = 16 + SCREEN_FRAC_BITS;   // quotient bits
  localparam int DRW = 49 + SCREEN_FRAC_BITS;   // divider remainder width
  localparam int QCW = $clog2(QW);
  localparam logic signed [WORD_W-1:0] ONE = WORD_W'(64'd1 << FRAC_BITS);

  typedef enum logic [2:0] {S_IDLE, S_MAT, S_DRAIN, S_CLIP, S_SCALE, S_DIV} state_t;

  state_t state;

  // configuration
  logic [CFG_W-1:0] vp_width, vp_height;
  logic             sym_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp_width  <= '0;
      vp_height <= '0;
      sym_depth <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_addr)
        CFG_VP_WIDTH:  vp_width  <= cfg_data;
        CFG_VP_HEIGHT: vp_height <= cfg_data;
        CFG_SYM_DEPTH: sym_depth <= cfg_data[0];
        default: ;
      endcase
    end
  end

  wire accept = start && !busy;
  wire load   = accept && (opcode == OP_LOAD);

  // matrix store, words never written read as zero
  logic [WORD_W-1:0] mem [32];
  logic [31:0]       mem_ok;
  logic [WORD_W-1:0] rd_data;
  logic              rd_ok;
  logic [3:0]        cnt;
  logic              stage;
  wire  [ADDR_W-1:0] rd_addr = {stage, cnt[1:0], cnt[3:2]};

  always_ff @(posedge clk) begin
    if (load) mem[entry_index] <= entry_value;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) mem_ok <= '0;
    else if (load) mem_ok[entry_index] <= 1'b1;
    rd_ok <= mem_ok[rd_addr];
  end

  wire logic signed [WORD_W-1:0] mword = rd_ok ? rd_data : '0;

  // datapath registers
  logic signed [WORD_W-1:0] px, py, pz;
  logic signed [WORD_W-1:0] vreg [4];
  logic signed [WORD_W-1:0] creg [4];
  logic                     rd_v, mul_v, ovf;
  logic [3:0]               rd_k, mul_k;
  logic signed [63:0]       prod, acc;
  logic                     axis;
  logic [32:0]              nh_x, nh_y;
  logic [32:0]              wpos;
  logic [DRW-1:0]           rem, dsh;
  logic [QW-1:0]            quo;
  logic [QCW-1:0]           dcnt;
  logic [SCREEN_W-1:0]      sx_hold;

  // vector operand for the shared multiplier
  logic signed [WORD_W-1:0] vsel;
  always_comb begin
    if (!stage) begin
      case (rd_k[1:0])
        2'd0:    vsel = px;
        2'd1:    vsel = py;
        2'd2:    vsel = pz;
        default: vsel = ONE;
      endcase
    end else begin
      vsel = vreg[rd_k[1:0]];
    end
  end

  // accumulate with overflow detect, floor shift at row end
  logic signed [63:0] acc_in, sh;
  logic [64:0]        sum65;
  logic               sum_ovf, sh_fit;
  always_comb begin
    acc_in  = (mul_k[1:0] == 2'd0) ? 64'sd0 : acc;
    sum65   = {acc_in[63], acc_in} + {prod[63], prod};
    sum_ovf = sum65[64] ^ sum65[63];
    sh      = $signed(sum65[63:0]) >>> FRAC_BITS;
    sh_fit  = (&sh[63:31]) || !(|sh[63:31]);
  end

  // clip box on the projected point
  logic signed [32:0] cx, cy, cz, cw;
  logic               clip_ok;
  always_comb begin
    cx = 33'(creg[0]);
    cy = 33'(creg[1]);
    cz = 33'(creg[2]);
    cw = 33'(creg[3]);
    clip_ok = !ovf && (cw > 0) && (cz >= (sym_depth ? -cw : 33'sd0)) && (cz <= cw)
              && (cx <= cw) && (-cx <= cw) && (cy <= cw) && (-cy <= cw);
  end

  // divider step and saturation
  logic                    ge;
  logic [63:0]             qwide;
  logic [SCREEN_W-1:0]     qsat;
  logic [47:0]             scaled;
  always_comb begin
    ge     = rem >= dsh;
    qwide  = 64'({quo[QW-2:0], ge});
    qsat   = (qwide > 64'(SCREEN_MAX)) ? SCREEN_MAX : qwide[SCREEN_W-1:0];
    scaled = 48'(axis ? nh_y : nh_x) * 48'(axis ? vp_height : vp_width);
  end

  assign busy = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
      cnt   <= '0;
      stage <= 1'b0;
    end else begin
      done  <= 1'b0;
      rd_v  <= (state == S_MAT);
      rd_k  <= cnt;
      mul_v <= rd_v;
      mul_k <= rd_k;
      prod  <= 64'(mword) * 64'(vsel);
      if (mul_v) begin
        acc <= sum65[63:0];
        if (sum_ovf || (mul_k[1:0] == 2'd3 && !sh_fit)) ovf <= 1'b1;
        if (mul_k[1:0] == 2'd3) begin
          if (!stage) vreg[mul_k[3:2]] <= sh[31:0];
          else        creg[mul_k[3:2]] <= sh[31:0];
        end
      end
      case (state)
        S_IDLE: begin
          if (accept && opcode == OP_PROJECT) begin
            px    <= point_x;
            py    <= point_y;
            pz    <= point_z;
            ovf   <= 1'b0;
            cnt   <= '0;
            stage <= 1'b0;
            if (vp_width == '0 || vp_height == '0) begin
              done     <= 1'b1;
              visible  <= 1'b0;
              screen_x <= '0;
              screen_y <= '0;
            end else begin
              state <= S_MAT;
            end
          end
        end
        S_MAT: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!rd_v && !mul_v) begin
            if (!stage) begin
              stage <= 1'b1;
              state <= S_MAT;
            end else begin
              state <= S_CLIP;
            end
          end
        end
        S_CLIP: begin
          if (!clip_ok) begin
            done     <= 1'b1;
            visible  <= 1'b0;
            screen_x <= '0;
            screen_y <= '0;
            state    <= S_IDLE;
          end else begin
            nh_x  <= 33'(cx + cw);
            nh_y  <= 33'(cw - cy);
            wpos  <= 33'(cw);
            axis  <= 1'b0;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          rem   <= (DRW'(scaled) << SCREEN_FRAC_BITS) + DRW'(wpos);
          dsh   <= DRW'({wpos, 1'b0}) << (QW - 1);
          quo   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (ge) rem <= rem - dsh;
          dsh  <= dsh >> 1;
          quo  <= qwide[QW-1:0];
          dcnt <= dcnt + QCW'(1);
          if (dcnt == QCW'(QW - 1)) begin
            if (!axis) begin
              sx_hold <= qsat;
              axis    <= 1'b1;
              state   <= S_SCALE;
            end else begin
              done     <= 1'b1;
              visible  <= 1'b1;
              screen_x <= sx_hold;
              screen_y <= qsat;
              state    <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `PVP_ASSERT(a_done_idle, done, !busy, "result beat while sequencer busy")
  `PVP_ASSERT(a_hidden_zero, done && !visible, screen_x == '0 && screen_y == '0,
    "hidden point with nonzero screen position")
  `PVP_ASSERT_NEXT(a_zero_vp, accept && opcode == OP_PROJECT && vp_width == '0,
    done && !visible, "zero viewport did not give hidden result")
  `PVP_ASSERT(a_mul_busy, mul_v, state == S_MAT || state == S_DRAIN,
    "multiply in flight outside matrix pass")
endmodule
`default_nettype wire

// ----- dv/point_view_projection_clip_tb.sv -----
// ----------------------------------------------------------------------------
// Point projection testbench
// Loads view/projection matrices and projects points under several viewport
// and depth settings. A clocked driver feeds beats from a queue, a clocked
// monitor predicts each projection in fixed point and checks visible/screen.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module point_view_projection_clip_tb;
  import pvp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int FRAC  = 16;
  localparam int SFRAC = 8;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] idx;
    logic [WORD_W-1:0] val, px, py, pz;
  } beat_t;

  typedef struct {
    logic                vis;
    logic [SCREEN_W-1:0] sx, sy;
  } proj_t;

  typedef longint vec4_t [4];

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic opcode = 0;
  logic [ADDR_W-1:0] entry_index = '0;
  logic signed [WORD_W-1:0] entry_value = '0, point_x = '0, point_y = '0, point_z = '0;
  logic cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic busy, done, visible;
  logic [SCREEN_W-1:0] screen_x, screen_y;

  point_view_projection_clip dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .entry_index(entry_index), .entry_value(entry_value),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .done(done), .visible(visible), .screen_x(screen_x), .screen_y(screen_y),
    .cfg_write(cfg_write), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [WORD_W-1:0] mat_words [32] = '{default: '0};
  longint vp_w = 0, vp_h = 0;
  bit sym_depth = 0;

  beat_t pending_beats [$];
  proj_t expected_proj [$];
  int errors = 0;
  int cycles = 0;
  bit beat_taken = 0;
  int burst_left = 0, gap_left = 0;

  // one matrix pass; returns 0 on overflow
  function automatic bit mat_pass(input int base, input vec4_t vin, output vec4_t vout);
    logic signed [65:0] acc;
    logic signed [65:0] sh;
    longint prod;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) begin
        prod = longint'($signed(mat_words[(base + c * 4 + r) & 31])) * vin[c];
        acc = acc + prod;
        if (acc[65:63] != 3'b000 && acc[65:63] != 3'b111) return 0;
      end
      sh = acc >>> FRAC;
      if (sh[65:31] != '0 && sh[65:31] != '1) return 0;
      vout[r] = longint'(sh[63:0]);
    end
    return 1;
  endfunction

  function automatic logic [SCREEN_W-1:0] screen_map(input longint num_half, input longint w,
                                                     input longint span);
    longint unsigned num, q;
    num = longint'(num_half * span) << SFRAC;
    q = (num + longint'(w)) / longint'(2 * w);
    return (q > SCREEN_MAX) ? SCREEN_MAX : q[SCREEN_W-1:0];
  endfunction

  function automatic proj_t project_point(input beat_t b);
    proj_t res;
    vec4_t p, v, c;
    longint x, y, z, w;
    res = '{vis: 0, sx: '0, sy: '0};
    if (vp_w == 0 || vp_h == 0) return res;
    p[0] = longint'($signed(b.px));
    p[1] = longint'($signed(b.py));
    p[2] = longint'($signed(b.pz));
    p[3] = longint'(1) << FRAC;
    if (!mat_pass(0, p, v)) return res;
    if (!mat_pass(16, v, c)) return res;
    x = c[0]; y = c[1]; z = c[2]; w = c[3];
    if (w <= 0) return res;
    if (z < (sym_depth ? -w : 0)) return res;
    if (z > w) return res;
    if (x > w || -x > w) return res;
    if (y > w || -y > w) return res;
    res.vis = 1;
    res.sx = screen_map(x + w, w, vp_w);
    res.sy = screen_map(w - y, w, vp_h);
    return res;
  endfunction

  // driver: bursts of beats with random gaps
  always @(negedge clk) begin
    beat_t b;
    if (!rst && (!start || beat_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 0;
      end else if (pending_beats.size() > 0) begin
        b = pending_beats.pop_front();
        opcode <= b.op;
        entry_index <= b.idx;
        entry_value <= b.val;
        point_x <= b.px;
        point_y <= b.py;
        point_z <= b.pz;
        start <= 1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 0;
      end
    end
  end

  // monitor: check results, predict accepted beats
  always @(posedge clk) begin
    proj_t got, want;
    beat_t b;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else if (!rst) begin
      if (done) begin
        got = '{vis: visible, sx: screen_x, sy: screen_y};
        if (expected_proj.size() == 0) begin
          if (errors < 10) $display("unexpected result vis=%0b x=%0d y=%0d",
                                    visible, screen_x, screen_y);
          errors++;
        end else begin
          want = expected_proj.pop_front();
          if (got.vis !== want.vis || got.sx !== want.sx || got.sy !== want.sy) begin
            if (errors < 10)
              $display("mismatch: vis exp %0b got %0b, x exp %0d got %0d, y exp %0d got %0d",
                       want.vis, got.vis, want.sx, got.sx, want.sy, got.sy);
            errors++;
          end
        end
      end
      beat_taken = start && !busy;
      if (beat_taken) begin
        b = '{op: opcode, idx: entry_index, val: entry_value,
              px: point_x, py: point_y, pz: point_z};
        if (b.op == OP_LOAD) mat_words[b.idx] = b.val;
        else expected_proj.insert(expected_proj.size(), project_point(b));
      end
    end
  end

  function automatic int srand(input int a);
    return int'($urandom_range(0, 2 * a)) - a;
  endfunction

  // append one beat to the driver queue
  task automatic queue_beat(input beat_t b);
    pending_beats.insert(pending_beats.size(), b);
  endtask

  task automatic add_load(input int idx, input logic [31:0] val);
    queue_beat('{op: OP_LOAD, idx: idx[ADDR_W-1:0], val: val,
                 px: $urandom, py: $urandom, pz: $urandom});
  endtask

  task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    queue_beat('{op: OP_PROJECT, idx: ADDR_W'($urandom), val: $urandom,
                 px: x, py: y, pz: z});
  endtask

  task automatic cfg_wr(input logic [CFG_IDX_W-1:0] a, input logic [CFG_W-1:0] d);
    @(negedge clk);
    cfg_write <= 1;
    cfg_addr <= a;
    cfg_data <= d;
    if (a == CFG_VP_WIDTH) vp_w = d;
    else if (a == CFG_VP_HEIGHT) vp_h = d;
    else if (a == CFG_SYM_DEPTH) sym_depth = d[0];
    @(negedge clk);
    cfg_write <= 0;
  endtask

  // drain: no beats queued, none in flight, plus a project's latency
  task automatic wait_idle();
    while (pending_beats.size() > 0 || start || expected_proj.size() > 0) @(posedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic load_identity();
    for (int i = 0; i < 32; i++) add_load(i, ((i & 15) % 5 == 0) ? 32'h10000 : 32'h0);
  endtask

  // plausible camera: near-identity view, perspective projection with w = -z
  task automatic load_camera(input bit noisy);
    int v;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (r == c) v = (r == 3) ? 65536 : 65536 + srand(8192);
        else if (r == 3) v = 0;
        else if (c == 3) v = srand(65536);
        else v = srand(4096);
        add_load(c * 4 + r, (noisy && $urandom_range(0, 7) == 0) ? $urandom : v);
      end
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        v = 0;
        if (r == 0 && c == 0) v = $urandom_range(32768, 131072);
        if (r == 1 && c == 1) v = $urandom_range(32768, 131072);
        if (r == 2 && c == 2) v = -int'($urandom_range(52000, 80000));
        if (r == 2 && c == 3) v = srand(98304) - 32768;
        if (r == 3 && c == 2) v = -65536;
        add_load(16 + c * 4 + r, (noisy && $urandom_range(0, 7) == 0) ? $urandom : v);
      end
  endtask

  task automatic camera_round(input int n);
    int z, m;
    load_camera($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: add_point($urandom, $urandom, $urandom);
        1: add_load($urandom_range(0, 31), $urandom);
        default: begin
          z = -int'($urandom_range(16384, 8 * 65536));
          m = -z + (-z) / 4;
          add_point(srand(m), srand(m), z);
        end
      endcase
    end
  endtask

  int cfg_set [6][3] = '{'{640, 480, 1}, '{1, 1, 0}, '{32767, 32767, 1},
                         '{16384, 1, 0}, '{0, 480, 1}, '{800, 600, 0}};

  initial begin
    repeat (12) @(negedge clk);
    rst <= 0;

    // zero viewport after reset: every point hidden, extreme fields
    add_load(0, 32'h7FFFFFFF);
    add_load(31, 32'h80000000);
    add_point(32'h80000000, 32'h7FFFFFFF, 32'h0);
    add_point(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    wait_idle();

    // identity matrices: clip box boundaries and depth modes
    cfg_wr(CFG_VP_WIDTH, 640);
    cfg_wr(CFG_VP_HEIGHT, 480);
    cfg_wr(CFG_SYM_DEPTH, 1);
    cfg_wr(CFG_SPARE, CFG_W'($urandom));
    load_identity();
    add_point(32'h10000, 32'hFFFF0000, 32'hFFFF0000);  // x = w, y = -w, z = -w
    add_point(32'hFFFF0000, 32'h10000, 32'h10000);     // x = -w, y = w, z = w
    add_point(32'h10001, 32'h0, 32'h0);                // just outside in x
    add_point(32'h0, 32'h0, 32'h10001);                // beyond far plane
    add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_load(15, 32'h0);                               // w = 0 hides point
    add_point(32'h0, 32'h0, 32'h0);
    add_load(15, 32'h10000);
    add_load(0, 32'h7FFFFFFF);                         // stage overflow
    add_point(32'h7FFFFFFF, 32'h0, 32'h0);
    wait_idle();
    cfg_wr(CFG_SYM_DEPTH, 0);
    add_point(32'h0, 32'h0, 32'hFFFF0000);             // z < 0 with near plane at 0
    add_point(32'h0, 32'h0, 32'h0);
    wait_idle();

    // random phases across viewport/depth settings
    for (int ph = 0; ph < 6; ph++) begin
      cfg_wr(CFG_VP_WIDTH, CFG_W'(cfg_set[ph][0]));
      cfg_wr(CFG_VP_HEIGHT, CFG_W'(cfg_set[ph][1]));
      cfg_wr(CFG_SYM_DEPTH, CFG_W'(cfg_set[ph][2]));
      cfg_wr(CFG_SPARE, CFG_W'($urandom));
      camera_round(28);
      camera_round(28);
      wait_idle();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/pvp_pkg.sv
hw/rtl/point_view_projection_clip.sv
dv/point_view_projection_clip_tb.sv
